// File: rtl/rqd_pkg.sv
// ----------------------------------------------------------------------------
// rqd_pkg: shared constants and types for the row quadratic detrend core
// widths of the sample path, the row sums, the fit terms and the divider
// ----------------------------------------------------------------------------
`default_nettype none

package rqd_pkg;

   localparam int MAX_ROW  = 512;
   localparam int MIN_ROW  = 3;
   localparam int SAMPLE_W = 32;
   localparam int LEN_W    = 10;
   localparam int CNT_W    = $clog2(MAX_ROW + 1);
   localparam int POS_W    = $clog2(MAX_ROW);
   localparam int ADDR_W   = $clog2(2 * MAX_ROW);
   localparam int CMP_W    = ((LEN_W > CNT_W) ? LEN_W : CNT_W) + 1;
   // multiplier operand, holds up to n^4
   localparam int MB_W     = 4 * CNT_W;
   // fit denominator n(n^2-1)(n^2-4)
   localparam int DEN_W    = 5 * CNT_W;
   // fit numerator and coefficient width
   localparam int ACC_W    = SAMPLE_W + 5 * CNT_W + 8;
   localparam int DIV_W    = ACC_W + 2;
   localparam int SY_W     = SAMPLE_W + POS_W + 1;
   localparam int SXY_W    = SY_W + POS_W + 1;
   localparam int SXXY_W   = SXY_W + POS_W + 1;

   localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = LEN_W'(512);

   typedef enum logic {
      OP_PUSH  = 1'b0,
      OP_FLUSH = 1'b1
   } opcode_type;

endpackage

`default_nettype wire

// File: rtl/rqd_channels.sv
// ----------------------------------------------------------------------------
// rqd channels: valid/ready interfaces of the row quadratic detrend core
// sample requests, residual responses and the row length write port
// ----------------------------------------------------------------------------
`default_nettype none

interface rqd_req_if import rqd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   opcode_type                 opcode;
   logic signed [SAMPLE_W-1:0] sample;
   modport source (output valid, opcode, sample, input ready);
   modport sink   (input valid, opcode, sample, output ready);
endinterface

interface rqd_rsp_if import rqd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] residual;
   logic                       row_end;
   logic                       saturated;
   modport source (output valid, residual, row_end, saturated, input ready);
   modport sink   (input valid, residual, row_end, saturated, output ready);
endinterface

interface rqd_csr_if import rqd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/row_quadratic_detrend_core.sv
// ----------------------------------------------------------------------------
// row_quadratic_detrend_core: least squares quadratic row flattening
// one transaction at a time; a push without a pending residual runs the
// row sum multiply steps between accepts, a drain adds three multiply
// steps, the divider (one quotient bit a cycle) and an emit step that waits
// for the output slot, and a row end adds the solve sequence of 16 multiply
// steps on the shared shift-add multiplier
// reset is synchronous active high, clears control state and the row sums;
// the row store holds no reset and is read only where its row wrote it
// ----------------------------------------------------------------------------
`default_nettype none

module row_quadratic_detrend_core import rqd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   rqd_req_if.sink      req_chan,
   rqd_rsp_if.source    rsp_chan,
   rqd_csr_if.sink      csr_chan
);

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOAD = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   // multiply steps: dest = a * b + c
   typedef enum logic [4:0] {
      SP_XX, SP_NA, SP_NB,                 // drain: fit numerator at x
      SP_XY, SP_XXY,                       // push: row sums
      SP_N2, SP_K1, SP_K0, SP_MM1, SP_KM,  // solve: length terms
      SP_DEN, SP_T1, SP_T2A, SP_T2B, SP_T2C,
      SP_CA, SP_CBA, SP_CBB, SP_CCA, SP_CCB, SP_CCC
   } step_type;

   localparam logic signed [MB_W-1:0] C1  = MB_W'(1);
   localparam logic signed [MB_W-1:0] C3  = MB_W'(3);
   localparam logic signed [MB_W-1:0] C5  = MB_W'(5);
   localparam logic signed [MB_W-1:0] C6  = MB_W'(6);
   localparam logic signed [MB_W-1:0] C30 = MB_W'(30);
   localparam logic signed [ACC_W-1:0] CM4 = -ACC_W'(4);
   localparam int DCNT_W = $clog2(DIV_W);
   localparam int REM_W  = DEN_W + 1;

   state_type state_ff;
   step_type  step_ff;

   // configuration and row bookkeeping
   logic [LEN_W-1:0] row_length_ff;
   logic             fill_bank_ff;
   logic [POS_W-1:0] fill_pos_ff;
   logic [POS_W-1:0] drain_pos_ff;
   logic [CNT_W-1:0] drain_len_ff;
   logic             pending_ff;
   logic [CNT_W-1:0] n_ff;

   // latched transaction
   opcode_type                 op_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;

   // sums, fit terms and coefficients
   logic signed [SY_W-1:0]   sy_ff;
   logic signed [SXY_W-1:0]  sxy_ff;
   logic signed [SXXY_W-1:0] sxxy_ff;
   logic signed [MB_W-1:0]   n2_ff, k1_ff, k0_ff, mm1_ff, km_ff, xx_ff;
   logic [DEN_W-1:0]         den_ff;
   logic signed [ACC_W-1:0]  t1_ff, t2_ff, ca_ff, cb_ff, cc_ff, num_ff, xy_ff;

   // shared shift-add multiplier
   logic signed [ACC_W-1:0] mul_acc_ff, mul_a_ff;
   logic signed [MB_W-1:0]  mul_b_ff;
   logic signed [ACC_W-1:0] op_a, op_c, mul_res_in;
   logic signed [MB_W-1:0]  op_b;
   logic                    mul_done;

   // restoring divider
   logic [REM_W-1:0]  div_rem_ff;
   logic [DIV_W-1:0]  div_q_ff;
   logic [DCNT_W-1:0] div_cnt_ff;
   logic              div_neg_ff;
   logic [REM_W:0]    div_shift;
   logic [REM_W:0]    div_dv;
   logic              div_ge;

   // row store, two banks
   logic [SAMPLE_W-1:0] row_store [2*MAX_ROW];
   logic [SAMPLE_W-1:0] store_rd_ff;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;

   // output register
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_res_ff;
   logic                       rsp_end_ff, rsp_sat_ff;

   logic                    accept;
   logic                    rsp_free;
   logic [CMP_W-1:0]        len_use;
   logic                    row_done;
   logic [CNT_W-1:0]        m_val;
   logic signed [MB_W-1:0]  m_mb, n_mb, x_mb, fx_mb;
   logic signed [ACC_W-1:0] x_acc, n_acc, m_acc;
   logic signed [DIV_W-1:0] div_v, div_mag, fit_val;
   logic signed [DIV_W:0]   res_wide;
   logic signed [SAMPLE_W-1:0] res_sat;
   logic                    res_clip;
   logic                    drain_last;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.residual  = rsp_res_ff;
   assign rsp_chan.row_end   = rsp_end_ff;
   assign rsp_chan.saturated = rsp_sat_ff;

   // length in use, clamped to the legal range
   always_comb begin
      if (CMP_W'(row_length_ff) < CMP_W'(MIN_ROW)) begin
         len_use = CMP_W'(MIN_ROW);
      end else if (CMP_W'(row_length_ff) > CMP_W'(MAX_ROW)) begin
         len_use = CMP_W'(MAX_ROW);
      end else begin
         len_use = CMP_W'(row_length_ff);
      end
   end

   assign row_done   = (CMP_W'(fill_pos_ff) + CMP_W'(1)) >= len_use;
   assign drain_last = (CNT_W'(drain_pos_ff) + CNT_W'(1)) >= drain_len_ff;

   // small operands, zero extended into signed words
   assign m_val = n_ff - CNT_W'(1);
   assign m_mb  = MB_W'($signed({1'b0, m_val}));
   assign n_mb  = MB_W'($signed({1'b0, n_ff}));
   assign x_mb  = MB_W'($signed({1'b0, drain_pos_ff}));
   assign fx_mb = MB_W'($signed({1'b0, fill_pos_ff}));
   assign x_acc = ACC_W'($signed({1'b0, drain_pos_ff}));
   assign n_acc = ACC_W'($signed({1'b0, n_ff}));
   assign m_acc = ACC_W'($signed({1'b0, m_val}));

   // operand table of the multiply steps
   always_comb begin
      op_a = '0;
      op_b = '0;
      op_c = '0;
      case (step_ff)
         SP_XX: begin
            op_a = x_acc; op_b = x_mb;
         end
         SP_NA: begin
            op_a = ca_ff; op_b = xx_ff; op_c = cc_ff;
         end
         SP_NB: begin
            op_a = cb_ff; op_b = x_mb; op_c = num_ff;
         end
         SP_XY: begin
            op_a = ACC_W'(sample_ff); op_b = fx_mb;
         end
         SP_XXY: begin
            op_a = xy_ff; op_b = fx_mb; op_c = ACC_W'(sxxy_ff);
         end
         SP_N2: begin
            op_a = n_acc; op_b = n_mb;
         end
         SP_K1: begin
            op_a = ACC_W'(n2_ff); op_b = C1; op_c = CM4;
         end
         SP_K0: begin
            op_a = ACC_W'(k1_ff); op_b = n2_ff; op_c = -ACC_W'(k1_ff);
         end
         SP_MM1: begin
            op_a = m_acc; op_b = m_mb; op_c = -m_acc;
         end
         SP_KM: begin
            op_a = ACC_W'(k1_ff); op_b = m_mb;
         end
         SP_DEN: begin
            op_a = ACC_W'(k0_ff); op_b = n_mb;
         end
         SP_T1: begin
            op_a = ACC_W'(sy_ff); op_b = -m_mb; op_c = ACC_W'(sxy_ff) <<< 1;
         end
         SP_T2A: begin
            op_a = ACC_W'(sxxy_ff); op_b = C6;
         end
         SP_T2B: begin
            op_a = ACC_W'(sxy_ff); op_b = -(C6 * m_mb); op_c = t2_ff;
         end
         SP_T2C: begin
            op_a = ACC_W'(sy_ff); op_b = mm1_ff; op_c = t2_ff;
         end
         SP_CA: begin
            op_a = t2_ff; op_b = C30;
         end
         SP_CBA: begin
            op_a = t1_ff; op_b = C6 * k1_ff;
         end
         SP_CBB: begin
            op_a = t2_ff; op_b = -(C30 * m_mb); op_c = cb_ff;
         end
         SP_CCA: begin
            op_a = ACC_W'(sy_ff); op_b = k0_ff;
         end
         SP_CCB: begin
            op_a = t1_ff; op_b = -(C3 * km_ff); op_c = cc_ff;
         end
         SP_CCC: begin
            op_a = t2_ff; op_b = C5 * mm1_ff; op_c = cc_ff;
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   // multiplier finishes once the remaining multiplier bits are all sign
   assign mul_done   = (mul_b_ff == '0) || (mul_b_ff == '1);
   assign mul_res_in = (mul_b_ff == '0) ? mul_acc_ff : (mul_acc_ff - mul_a_ff);

   // divider setup: 2*num + den, floor division by 2*den
   assign div_v   = (DIV_W'(mul_res_in) <<< 1) + DIV_W'($signed({1'b0, den_ff}));
   assign div_mag = div_v[DIV_W-1] ?
                    (-div_v + (DIV_W'($signed({1'b0, den_ff})) <<< 1) - DIV_W'(1)) : div_v;

   assign div_shift = {div_rem_ff, div_q_ff[DIV_W-1]};
   assign div_dv    = (REM_W+1)'({den_ff, 1'b0});
   assign div_ge    = div_shift >= div_dv;

   // residual and saturation
   assign fit_val  = div_neg_ff ? -$signed(div_q_ff) : $signed(div_q_ff);
   assign res_wide = (DIV_W+1)'($signed(store_rd_ff)) - (DIV_W+1)'(fit_val);

   always_comb begin
      res_clip = 1'b0;
      res_sat  = SAMPLE_W'(res_wide);
      if (res_wide > (DIV_W+1)'($signed({1'b0, {(SAMPLE_W-1){1'b1}}}))) begin
         res_clip = 1'b1;
         res_sat  = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (res_wide < (DIV_W+1)'($signed({1'b1, {(SAMPLE_W-1){1'b0}}}))) begin
         res_clip = 1'b1;
         res_sat  = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end
   end

   // bank addresses: write fills the current bank, read drains the other one
   assign wr_addr = fill_bank_ff ? (ADDR_W'(MAX_ROW) + ADDR_W'(fill_pos_ff)) : ADDR_W'(fill_pos_ff);
   assign rd_addr = fill_bank_ff ? ADDR_W'(drain_pos_ff) : (ADDR_W'(MAX_ROW) + ADDR_W'(drain_pos_ff));

   always_ff @(posedge clock) begin
      if (accept && req_chan.opcode == OP_PUSH) begin
         row_store[wr_addr] <= req_chan.sample;
      end
      if (accept) begin
         store_rd_ff <= row_store[rd_addr];
      end
   end

   // payload registers of the datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_chan.opcode;
         sample_ff <= req_chan.sample;
      end
      if (state_ff == ST_LOAD) begin
         mul_acc_ff <= op_c;
         mul_a_ff   <= op_a;
         mul_b_ff   <= op_b;
      end else if (state_ff == ST_MUL && !mul_done) begin
         if (mul_b_ff[0]) begin
            mul_acc_ff <= mul_acc_ff + mul_a_ff;
         end
         mul_a_ff <= mul_a_ff <<< 1;
         mul_b_ff <= mul_b_ff >>> 1;
      end
      if (state_ff == ST_MUL && mul_done) begin
         case (step_ff)
            SP_XX:  xx_ff  <= MB_W'(mul_res_in);
            SP_NA:  num_ff <= mul_res_in;
            SP_NB: begin
               num_ff     <= mul_res_in;
               div_neg_ff <= div_v[DIV_W-1];
               div_q_ff   <= div_mag;
               div_rem_ff <= '0;
            end
            SP_XY:  xy_ff  <= mul_res_in;
            SP_N2:  n2_ff  <= MB_W'(mul_res_in);
            SP_K1:  k1_ff  <= MB_W'(mul_res_in);
            SP_K0:  k0_ff  <= MB_W'(mul_res_in);
            SP_MM1: mm1_ff <= MB_W'(mul_res_in);
            SP_KM:  km_ff  <= MB_W'(mul_res_in);
            SP_DEN: den_ff <= DEN_W'(mul_res_in);
            SP_T1:  t1_ff  <= mul_res_in;
            SP_T2A, SP_T2B, SP_T2C: t2_ff <= mul_res_in;
            SP_CA:  ca_ff  <= mul_res_in;
            SP_CBA, SP_CBB: cb_ff <= mul_res_in;
            SP_CCA, SP_CCB, SP_CCC: cc_ff <= mul_res_in;
            default: begin
            end
         endcase
      end
      if (state_ff == ST_DIV) begin
         if (div_ge) begin
            div_rem_ff <= REM_W'(div_shift - div_dv);
            div_q_ff   <= {div_q_ff[DIV_W-2:0], 1'b1};
         end else begin
            div_rem_ff <= REM_W'(div_shift);
            div_q_ff   <= {div_q_ff[DIV_W-2:0], 1'b0};
         end
      end
      if (state_ff == ST_EMIT && rsp_free) begin
         rsp_res_ff <= res_sat;
         rsp_sat_ff <= res_clip;
         rsp_end_ff <= drain_last;
      end
   end

   // control: sequencer, row bookkeeping, sums and the output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= SP_XX;
         row_length_ff <= ROW_LENGTH_RESET;
         fill_bank_ff  <= 1'b0;
         fill_pos_ff   <= '0;
         drain_pos_ff  <= '0;
         drain_len_ff  <= '0;
         pending_ff    <= 1'b0;
         n_ff          <= '0;
         sy_ff         <= '0;
         sxy_ff        <= '0;
         sxxy_ff       <= '0;
         div_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            row_length_ff <= csr_chan.data;
         end
         // output slot: loaded by emit, freed when the sink takes it
         if (state_ff == ST_EMIT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               // a pending residual drains before the new sample lands
               if (accept) begin
                  if (pending_ff) begin
                     step_ff  <= SP_XX;
                     state_ff <= ST_LOAD;
                  end else if (req_chan.opcode == OP_PUSH) begin
                     step_ff  <= SP_XY;
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_LOAD: begin
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               if (mul_done) begin
                  case (step_ff)
                     SP_XX: begin
                        step_ff <= SP_NA; state_ff <= ST_LOAD;
                     end
                     SP_NA: begin
                        step_ff <= SP_NB; state_ff <= ST_LOAD;
                     end
                     SP_NB: begin
                        div_cnt_ff <= '0;
                        state_ff   <= ST_DIV;
                     end
                     SP_XY: begin
                        sxy_ff   <= sxy_ff + SXY_W'(mul_res_in);
                        sy_ff    <= sy_ff + SY_W'(sample_ff);
                        step_ff  <= SP_XXY;
                        state_ff <= ST_LOAD;
                     end
                     SP_XXY: begin
                        sxxy_ff <= SXXY_W'(mul_res_in);
                        if (row_done) begin
                           n_ff     <= CNT_W'(fill_pos_ff) + CNT_W'(1);
                           step_ff  <= SP_N2;
                           state_ff <= ST_LOAD;
                        end else begin
                           fill_pos_ff <= fill_pos_ff + POS_W'(1);
                           state_ff    <= ST_IDLE;
                        end
                     end
                     SP_N2: begin
                        step_ff <= SP_K1; state_ff <= ST_LOAD;
                     end
                     SP_K1: begin
                        step_ff <= SP_K0; state_ff <= ST_LOAD;
                     end
                     SP_K0: begin
                        step_ff <= SP_MM1; state_ff <= ST_LOAD;
                     end
                     SP_MM1: begin
                        step_ff <= SP_KM; state_ff <= ST_LOAD;
                     end
                     SP_KM: begin
                        step_ff <= SP_DEN; state_ff <= ST_LOAD;
                     end
                     SP_DEN: begin
                        step_ff <= SP_T1; state_ff <= ST_LOAD;
                     end
                     SP_T1: begin
                        step_ff <= SP_T2A; state_ff <= ST_LOAD;
                     end
                     SP_T2A: begin
                        step_ff <= SP_T2B; state_ff <= ST_LOAD;
                     end
                     SP_T2B: begin
                        step_ff <= SP_T2C; state_ff <= ST_LOAD;
                     end
                     SP_T2C: begin
                        step_ff <= SP_CA; state_ff <= ST_LOAD;
                     end
                     SP_CA: begin
                        step_ff <= SP_CBA; state_ff <= ST_LOAD;
                     end
                     SP_CBA: begin
                        step_ff <= SP_CBB; state_ff <= ST_LOAD;
                     end
                     SP_CBB: begin
                        step_ff <= SP_CCA; state_ff <= ST_LOAD;
                     end
                     SP_CCA: begin
                        step_ff <= SP_CCB; state_ff <= ST_LOAD;
                     end
                     SP_CCB: begin
                        step_ff <= SP_CCC; state_ff <= ST_LOAD;
                     end
                     SP_CCC: begin
                        // row solved: swap banks and start draining it
                        drain_len_ff <= n_ff;
                        fill_bank_ff <= !fill_bank_ff;
                        fill_pos_ff  <= '0;
                        drain_pos_ff <= '0;
                        pending_ff   <= 1'b1;
                        sy_ff        <= '0;
                        sxy_ff       <= '0;
                        sxxy_ff      <= '0;
                        state_ff     <= ST_IDLE;
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_DIV: begin
               div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
               if (div_cnt_ff == DCNT_W'(DIV_W - 1)) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp_free) begin
                  if (drain_last) begin
                     pending_ff   <= 1'b0;
                     drain_pos_ff <= '0;
                  end else begin
                     drain_pos_ff <= drain_pos_ff + POS_W'(1);
                  end
                  if (op_ff == OP_PUSH) begin
                     step_ff  <= SP_XY;
                     state_ff <= ST_LOAD;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   // a residual is only produced while a row is pending
   a_emit_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> pending_ff)
      else $error("residual emitted with no pending row");

   // divider never runs on a zero denominator
   a_div_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (den_ff != '0))
      else $error("divider started with zero denominator");

   // a clipped residual sits at one of the rails
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |->
         (rsp_res_ff == {1'b0, {(SAMPLE_W-1){1'b1}}} ||
          rsp_res_ff == {1'b1, {(SAMPLE_W-1){1'b0}}}))
      else $error("saturated flag without a rail value");

   // the output slot is never overwritten while still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && !rsp_chan.ready) |=> (state_ff == ST_EMIT))
      else $error("emit left while output slot was full");
`endif

endmodule

`default_nettype wire
